@@ rtl/kway_merge_with_duplicate_combine_defines.svh @@
// assertion macros for the merge block
// no dependencies; included by the top level
`ifndef KWAY_MERGE_WITH_DUPLICATE_COMBINE_DEFINES_SVH
`define KWAY_MERGE_WITH_DUPLICATE_COMBINE_DEFINES_SVH
`ifndef SYNTHESIS
`define KMDC_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("kmdc assertion failed");
`define KMDC_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("kmdc assertion failed");
`else
`define KMDC_ASSERT_IMP(name, cond, prop)
`define KMDC_ASSERT_NXT(name, cond, prop)
`endif
`endif

@@ rtl/kmdc_pkg.sv @@
// shared constants, state encoding and control structs of the merge block
// no dependencies
`timescale 1ns / 1ps
package kmdc_pkg;
    localparam int MAX_SOURCES = 16;
    localparam int SRC_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int LIVE_W = $clog2(MAX_SOURCES + 1);
    localparam int IN_SRC_W = 4;
    localparam int CFG_W  = 5;
    localparam int T_W = 56;
    localparam int A_W = 64;
    localparam int P_W = 32;
    localparam int L_W = 40;
    localparam int KEY_W = T_W + A_W + P_W + L_W;
    localparam int CNT_W = 32;
    localparam int ENTRY_W = KEY_W + CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CHECK   = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_COMBINE = 5'b01000,
        ST_FLUSH   = 5'b10000
    } state_t;

    typedef struct packed {
        logic take;
        logic scan_start;
        logic scan_step;
        logic combine;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic blocked;
        logic empty;
        logic scan_done;
        logic need_emit;
        logic held_valid;
        logic out_busy;
    } status_t;
endpackage

@@ rtl/kway_merge_with_duplicate_combine.sv @@
// top level of the k-way flow record merge with duplicate combining
// depends on kmdc_pkg, kmdc_ctrl, kmdc_dp (and kmdc_ram below it)
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    source, end flag, record fields, count
//   m_       out        m_valid/m_ready    merged record fields, count, last flag
//   cfg_     in         cfg_wr_en          active source count
//
// a transfer that leaves some live source still without a head passes accept and
// check only; one that allows a pop runs accept, check, a scan of the head ram at
// one entry per cycle through its registered read port, and a combine step
// reset clears all source flags and the held record; the head ram needs no clearing
// a stalled result waits in the output register; only the next emit waits on it
`timescale 1ns / 1ps
`include "kway_merge_with_duplicate_combine_defines.svh"
module kway_merge_with_duplicate_combine import kmdc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_SRC_W-1:0] s_source,
    input  logic                s_is_end,
    input  logic [T_W-1:0]      s_time_proto_ttl_flags,
    input  logic [A_W-1:0]      s_address_pair,
    input  logic [P_W-1:0]      s_port_pair,
    input  logic [L_W-1:0]      s_length_fields,
    input  logic [CNT_W-1:0]    s_packet_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [T_W-1:0]      m_out_time_proto_ttl_flags,
    output logic [A_W-1:0]      m_out_address_pair,
    output logic [P_W-1:0]      m_out_port_pair,
    output logic [L_W-1:0]      m_out_length_fields,
    output logic [CNT_W-1:0]    m_merged_count,
    output logic                m_last_record
);
    cmd_t    cmd;
    status_t status;

    // sequencer
    kmdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // head store, flags, held record and output register
    kmdc_dp u_dp (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .cmd                        (cmd),
        .status                     (status),
        .cfg_wr_en                  (cfg_wr_en),
        .cfg_wr_data                (cfg_wr_data),
        .s_source                   (s_source),
        .s_is_end                   (s_is_end),
        .s_time_proto_ttl_flags     (s_time_proto_ttl_flags),
        .s_address_pair             (s_address_pair),
        .s_port_pair                (s_port_pair),
        .s_length_fields            (s_length_fields),
        .s_packet_count             (s_packet_count),
        .m_valid                    (m_valid),
        .m_ready                    (m_ready),
        .m_out_time_proto_ttl_flags (m_out_time_proto_ttl_flags),
        .m_out_address_pair         (m_out_address_pair),
        .m_out_port_pair            (m_out_port_pair),
        .m_out_length_fields        (m_out_length_fields),
        .m_merged_count             (m_merged_count),
        .m_last_record              (m_last_record)
    );

    // s_ready drops right after an accepted transfer, while the check state runs
    `KMDC_ASSERT_NXT(a_busy_after_take, s_valid && s_ready, !s_ready)
    // a pending result is never overwritten by a later emit
    `KMDC_ASSERT_NXT(a_out_held, m_valid && !m_ready, m_valid && $stable(m_merged_count))
    // a new result only appears when the sequencer emits
    `KMDC_ASSERT_NXT(a_emit_source, !m_valid && !(cmd.combine || cmd.flush), !m_valid)
endmodule

@@ rtl/kmdc_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module kmdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/kmdc_ctrl.sv @@
// sequencer of the merge block: accept, check, scan, combine, flush
// depends on kmdc_pkg
`timescale 1ns / 1ps
module kmdc_ctrl import kmdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.blocked) begin
                    state_next = ST_IDLE;
                end else if (status.empty) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_COMBINE;
                end
            end
            ST_COMBINE: begin
                // wait for the output register when a record must leave
                if (!(status.need_emit && status.out_busy)) begin
                    cmd.combine = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (!(status.held_valid && status.out_busy)) begin
                    cmd.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/kmdc_dp.sv @@
// datapath of the merge block: head store, source flags, min scan, held record, output
// depends on kmdc_pkg and kmdc_ram
`timescale 1ns / 1ps
module kmdc_dp import kmdc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    input  logic [IN_SRC_W-1:0] s_source,
    input  logic                s_is_end,
    input  logic [T_W-1:0]      s_time_proto_ttl_flags,
    input  logic [A_W-1:0]      s_address_pair,
    input  logic [P_W-1:0]      s_port_pair,
    input  logic [L_W-1:0]      s_length_fields,
    input  logic [CNT_W-1:0]    s_packet_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [T_W-1:0]      m_out_time_proto_ttl_flags,
    output logic [A_W-1:0]      m_out_address_pair,
    output logic [P_W-1:0]      m_out_port_pair,
    output logic [L_W-1:0]      m_out_length_fields,
    output logic [CNT_W-1:0]    m_merged_count,
    output logic                m_last_record
);
    logic [CFG_W-1:0]       cfg_reg;
    logic [LIVE_W-1:0]      nlive;
    logic [MAX_SOURCES-1:0] waiting_reg, waiting_next;
    logic [MAX_SOURCES-1:0] ended_reg, ended_next;
    logic [MAX_SOURCES-1:0] present;
    logic                   src_ok;
    logic [SRC_W-1:0]       src_idx;
    logic [LIVE_W-1:0]      scan_reg;
    logic                   rd_pend_reg;
    logic [SRC_W-1:0]       rd_idx_reg;
    logic [ENTRY_W-1:0]     rd_data;
    logic                   best_valid_reg;
    logic [SRC_W-1:0]       best_idx_reg;
    logic [KEY_W-1:0]       best_key_reg;
    logic [CNT_W-1:0]       best_cnt_reg;
    logic                   held_valid_reg;
    logic [KEY_W-1:0]       held_key_reg;
    logic [CNT_W-1:0]       held_cnt_reg;
    logic [CNT_W:0]         sum;
    logic                   equal;
    logic                   m_valid_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic [CNT_W-1:0]       out_cnt_reg;
    logic                   out_last_reg;
    logic                   blocked;
    logic                   ram_we;

    // zero acts as one, above the limit clamps
    always_comb begin
        if (cfg_reg == '0) begin
            nlive = LIVE_W'(1);
        end else if (32'(cfg_reg) > MAX_SOURCES) begin
            nlive = LIVE_W'(MAX_SOURCES);
        end else begin
            nlive = LIVE_W'(cfg_reg);
        end
    end

    assign src_ok  = 32'(s_source) < 32'(nlive);
    assign src_idx = SRC_W'(s_source);
    assign ram_we  = cmd.take && src_ok && !ended_reg[src_idx] && waiting_reg[src_idx]
                     && !s_is_end;
    assign present = ~waiting_reg & ~ended_reg;

    always_comb begin
        blocked = 1'b0;
        for (int s = 0; s < MAX_SOURCES; s++) begin
            if (s < 32'(nlive) && waiting_reg[s] && !ended_reg[s]) begin
                blocked = 1'b1;
            end
        end
    end

    kmdc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SOURCES)) u_heads (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (src_idx),
        .wr_data ({s_time_proto_ttl_flags, s_address_pair, s_port_pair,
                   s_length_fields, s_packet_count}),
        .rd_addr (scan_reg[SRC_W-1:0]),
        .rd_data (rd_data)
    );

    assign equal = held_valid_reg && (held_key_reg == best_key_reg);
    assign sum   = {1'b0, held_cnt_reg} + {1'b0, best_cnt_reg};

    always_comb begin
        waiting_next = waiting_reg;
        ended_next   = ended_reg;
        if (cmd.take && src_ok && !ended_reg[src_idx] && waiting_reg[src_idx]) begin
            waiting_next[src_idx] = 1'b0;
            if (s_is_end) begin
                ended_next[src_idx] = 1'b1;
            end
        end
        if (cmd.combine) begin
            waiting_next[best_idx_reg] = 1'b1;
        end
        if (cmd.flush) begin
            waiting_next = '1;
            ended_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg        <= CFG_W'(1);
            waiting_reg    <= '1;
            ended_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_key_reg   <= '0;
            held_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
            rd_pend_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            scan_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            waiting_reg <= waiting_next;
            ended_reg   <= ended_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // min scan: one read per cycle, compare when data returns
            if (cmd.scan_start) begin
                scan_reg       <= '0;
                rd_pend_reg    <= 1'b0;
                best_valid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                if (32'(scan_reg) < MAX_SOURCES) begin
                    scan_reg    <= scan_reg + LIVE_W'(1);
                    rd_pend_reg <= 1'b1;
                end else begin
                    rd_pend_reg <= 1'b0;
                end
                if (rd_pend_reg && present[rd_idx_reg] &&
                    (!best_valid_reg || rd_data[ENTRY_W-1:CNT_W] < best_key_reg)) begin
                    best_valid_reg <= 1'b1;
                end
            end

            if (cmd.combine) begin
                if (equal) begin
                    held_cnt_reg <= sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                end else begin
                    if (held_valid_reg) begin
                        m_valid_reg <= 1'b1;
                    end
                    held_valid_reg <= 1'b1;
                    held_key_reg   <= best_key_reg;
                    held_cnt_reg   <= best_cnt_reg;
                end
            end
            if (cmd.flush) begin
                if (held_valid_reg) begin
                    m_valid_reg <= 1'b1;
                end
                held_valid_reg <= 1'b0;
                held_key_reg   <= '0;
                held_cnt_reg   <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            rd_idx_reg <= scan_reg[SRC_W-1:0];
            if (rd_pend_reg && present[rd_idx_reg] &&
                (!best_valid_reg || rd_data[ENTRY_W-1:CNT_W] < best_key_reg)) begin
                best_idx_reg <= rd_idx_reg;
                best_key_reg <= rd_data[ENTRY_W-1:CNT_W];
                best_cnt_reg <= rd_data[CNT_W-1:0];
            end
        end
        if ((cmd.combine && !equal && held_valid_reg) || (cmd.flush && held_valid_reg)) begin
            out_key_reg  <= held_key_reg;
            out_cnt_reg  <= held_cnt_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign status.blocked    = blocked;
    assign status.empty      = (present == '0);
    assign status.scan_done  = (32'(scan_reg) == MAX_SOURCES) && !rd_pend_reg;
    assign status.need_emit  = held_valid_reg && !equal;
    assign status.held_valid = held_valid_reg;
    assign status.out_busy   = m_valid_reg;

    assign m_valid                    = m_valid_reg;
    assign m_out_time_proto_ttl_flags = out_key_reg[KEY_W-1 -: T_W];
    assign m_out_address_pair         = out_key_reg[P_W+L_W +: A_W];
    assign m_out_port_pair            = out_key_reg[L_W +: P_W];
    assign m_out_length_fields        = out_key_reg[L_W-1:0];
    assign m_merged_count             = out_cnt_reg;
    assign m_last_record              = out_last_reg;
endmodule

@@ dv/tb_kway_merge_with_duplicate_combine.sv @@
// self-checking testbench for the k-way flow record merge with duplicate combining
// depends on kmdc_pkg and the kway_merge_with_duplicate_combine rtl
`timescale 1ns / 1ps
module tb_kway_merge_with_duplicate_combine;
    import kmdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ITEM_TARGET    = 1650;

    typedef struct {
        logic [IN_SRC_W-1:0] source;
        logic                is_end;
        logic [T_W-1:0]      t;
        logic [A_W-1:0]      a;
        logic [P_W-1:0]      p;
        logic [L_W-1:0]      l;
        logic [CNT_W-1:0]    cnt;
    } flow_rec_t;

    typedef struct {
        logic [T_W-1:0]   t;
        logic [A_W-1:0]   a;
        logic [P_W-1:0]   p;
        logic [L_W-1:0]   l;
        logic [CNT_W-1:0] cnt;
        logic [3:0]       origin;
    } head_t;

    typedef struct {
        logic [T_W-1:0]   t;
        logic [A_W-1:0]   a;
        logic [P_W-1:0]   p;
        logic [L_W-1:0]   l;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } merged_rec_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [IN_SRC_W-1:0] s_source = '0;
    logic                s_is_end = 1'b0;
    logic [T_W-1:0]      s_time_proto_ttl_flags = '0;
    logic [A_W-1:0]      s_address_pair = '0;
    logic [P_W-1:0]      s_port_pair = '0;
    logic [L_W-1:0]      s_length_fields = '0;
    logic [CNT_W-1:0]    s_packet_count = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [T_W-1:0]      m_out_time_proto_ttl_flags;
    logic [A_W-1:0]      m_out_address_pair;
    logic [P_W-1:0]      m_out_port_pair;
    logic [L_W-1:0]      m_out_length_fields;
    logic [CNT_W-1:0]    m_merged_count;
    logic                m_last_record;

    always #5 aclk = ~aclk;

    kway_merge_with_duplicate_combine DUT (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .cfg_wr_en                  (cfg_wr_en),
        .cfg_wr_data                (cfg_wr_data),
        .s_valid                    (s_valid),
        .s_ready                    (s_ready),
        .s_source                   (s_source),
        .s_is_end                   (s_is_end),
        .s_time_proto_ttl_flags     (s_time_proto_ttl_flags),
        .s_address_pair             (s_address_pair),
        .s_port_pair                (s_port_pair),
        .s_length_fields            (s_length_fields),
        .s_packet_count             (s_packet_count),
        .m_valid                    (m_valid),
        .m_ready                    (m_ready),
        .m_out_time_proto_ttl_flags (m_out_time_proto_ttl_flags),
        .m_out_address_pair         (m_out_address_pair),
        .m_out_port_pair            (m_out_port_pair),
        .m_out_length_fields        (m_out_length_fields),
        .m_merged_count             (m_merged_count),
        .m_last_record              (m_last_record)
    );

    // ---------------------------------------------------------------
    // merge predictor: own copy of source flags, head set and held record
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] live_cfg = 5'd1;
    head_t            heads[$];
    logic             awaiting[MAX_SOURCES];
    logic             ended[MAX_SOURCES];
    logic             held_ok;
    head_t            held;
    merged_rec_t      merged_expected[$];
    flow_rec_t        pending_items[$];
    bit               merge_done;
    bit               item_ignored;
    int               useful_items = 0;
    int               errors = 0;

    function automatic int live_sources();
        if (live_cfg == 0) return 1;
        if (live_cfg > MAX_SOURCES) return MAX_SOURCES;
        return live_cfg;
    endfunction

    task automatic clear_merge();
        heads.delete();
        for (int s = 0; s < MAX_SOURCES; s++) begin
            awaiting[s] = 1'b1;
            ended[s] = 1'b0;
        end
        held_ok = 1'b0;
        held = '{default: '0};
    endtask

    // apply one input transfer; results go to merged_expected
    task automatic merge_predict(flow_rec_t r);
        int          n;
        int          best;
        bit          blocked;
        head_t       h;
        logic [32:0] sum;
        n = live_sources();
        merge_done = 0;
        item_ignored = 1;
        if (r.source < n && !ended[r.source] && awaiting[r.source]) begin
            item_ignored = 0;
            awaiting[r.source] = 1'b0;
            if (r.is_end) ended[r.source] = 1'b1;
            else if (heads.size() < MAX_SOURCES)
                heads.push_back('{r.t, r.a, r.p, r.l, r.cnt, r.source});
        end
        blocked = 0;
        for (int s = 0; s < n; s++)
            if (awaiting[s] && !ended[s]) blocked = 1;
        if (blocked) return;
        // every source ended: flush the held record flagged last
        if (heads.size() == 0) begin
            if (held_ok)
                merged_expected.push_back('{held.t, held.a, held.p, held.l, held.cnt, 1'b1});
            clear_merge();
            merge_done = 1;
            return;
        end
        // smallest key wins, lower source index on a tie
        best = 0;
        for (int i = 1; i < heads.size(); i++)
            if ({heads[i].t, heads[i].a, heads[i].p, heads[i].l, heads[i].origin} <
                {heads[best].t, heads[best].a, heads[best].p, heads[best].l,
                 heads[best].origin})
                best = i;
        h = heads[best];
        heads.delete(best);
        awaiting[h.origin] = 1'b1;
        if (held_ok && held.t == h.t && held.a == h.a && held.p == h.p && held.l == h.l) begin
            sum = held.cnt + h.cnt;
            held.cnt = sum[32] ? '1 : sum[31:0];
            return;
        end
        if (held_ok)
            merged_expected.push_back('{held.t, held.a, held.p, held.l, held.cnt, 1'b0});
        held_ok = 1'b1;
        held = h;
    endtask

    task automatic send(flow_rec_t r);
        merge_predict(r);
        if (!item_ignored) useful_items++;
        pending_items.push_back(r);
    endtask

    function automatic flow_rec_t make_rec(int src, bit fin, logic [T_W-1:0] t,
                                           logic [A_W-1:0] a, logic [P_W-1:0] p,
                                           logic [L_W-1:0] l, logic [CNT_W-1:0] c);
        flow_rec_t r;
        r.source = src[3:0];
        r.is_end = fin;
        r.t = t;
        r.a = a;
        r.p = p;
        r.l = l;
        r.cnt = c;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one; none at all in burst stretches
    bit burst = 0;
    function automatic int gap_len();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------------------------------------------------------
    // input driver: changes at the falling edge
    // ---------------------------------------------------------------
    logic in_taken = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;

    always @(negedge aclk) begin
        flow_rec_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold until the transfer happens
        end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            r = pending_items.pop_front();
            s_valid <= 1'b1;
            s_source <= r.source;
            s_is_end <= r.is_end;
            s_time_proto_ttl_flags <= r.t;
            s_address_pair <= r.a;
            s_port_pair <= r.p;
            s_length_fields <= r.l;
            s_packet_count <= r.cnt;
            in_gap <= gap_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            m_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
        end
    end

    // ---------------------------------------------------------------
    // monitor and watchdog: sampled at the rising edge
    // ---------------------------------------------------------------
    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    int idle_cycles = 0;

    always @(posedge aclk) begin
        merged_rec_t e;
        in_taken <= s_valid && s_ready;
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (merged_expected.size() == 0) begin
                report("unexpected result transfer", 64'(m_merged_count), '0);
            end else begin
                e = merged_expected.pop_front();
                if (m_out_time_proto_ttl_flags !== e.t)
                    report("time_proto_ttl_flags", 64'(m_out_time_proto_ttl_flags),
                           64'(e.t));
                if (m_out_address_pair !== e.a)
                    report("address_pair", m_out_address_pair, e.a);
                if (m_out_port_pair !== e.p)
                    report("port_pair", 64'(m_out_port_pair), 64'(e.p));
                if (m_out_length_fields !== e.l)
                    report("length_fields", 64'(m_out_length_fields), 64'(e.l));
                if (m_merged_count !== e.cnt)
                    report("merged_count", 64'(m_merged_count), 64'(e.cnt));
                if (m_last_record !== e.last)
                    report("last_record", 64'(m_last_record), 64'(e.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencing
    // ---------------------------------------------------------------
    // idle means every transfer taken, every result seen, plus pop latency
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() > 0 || s_valid || merged_expected.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sources(logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        live_cfg = v;
    endtask

    logic [T_W-1:0] t_pool[4] = '{56'h0, 56'hFF_FFFF_FFFF_FFFF, 56'h0000_0010_0640_12,
                                  56'h8000_0000_1140_00};
    logic [A_W-1:0] a_pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0A00_0001_C0A8_0101,
                                  64'h7F00_0001_7F00_0001};

    // one merge of streams drawn mostly from shared key pools to force duplicates, with noise
    task automatic random_merge();
        int             n;
        int             remain[MAX_SOURCES];
        logic [31:0]    stamp[MAX_SOURCES];
        int             ready_src[$];
        int             s;
        logic [T_W-1:0] t;
        logic [A_W-1:0] a;
        logic [P_W-1:0] p;
        logic [L_W-1:0] l;
        logic [CNT_W-1:0] c;
        n = live_sources();
        for (int i = 0; i < MAX_SOURCES; i++) begin
            remain[i] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            stamp[i] = $urandom_range(0, 3);
        end
        merge_done = 0;
        while (!merge_done) begin
            if ($urandom_range(0, 99) < 8) begin
                // noise: any source, any fields
                send(make_rec($urandom_range(0, 15), 1'($urandom_range(0, 1)),
                              T_W'(rand64()), rand64(), $urandom, L_W'(rand64()),
                              $urandom));
                continue;
            end
            ready_src.delete();
            for (int i = 0; i < n; i++)
                if (awaiting[i] && !ended[i]) ready_src.push_back(i);
            if (ready_src.size() == 0) break;
            s = ready_src[$urandom_range(0, ready_src.size() - 1)];
            if (remain[s] == 0) begin
                send(make_rec(s, 1'b1, T_W'(rand64()), rand64(), $urandom,
                              L_W'(rand64()), $urandom));
                continue;
            end
            remain[s]--;
            stamp[s] += $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                t = T_W'(rand64());
                a = rand64();
                p = $urandom;
                l = L_W'(rand64());
            end else begin
                t = {stamp[s], t_pool[$urandom_range(0, 1) + 2][23:0]};
                a = a_pool[$urandom_range(0, 3)];
                p = ($urandom_range(0, 1) == 0) ? 32'h0050_C350 : 32'h01BB_D431;
                l = ($urandom_range(0, 1) == 0) ? 40'h0028_00_FFFF : 40'h05DC_00_0000;
            end
            case ($urandom_range(0, 3))
                0: c = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                1: c = $urandom;
                default: c = $urandom_range(0, 20);
            endcase
            send(make_rec(s, 1'b0, t, a, p, l, c));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] phase_cfg[6];
        int phase;
        phase_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3};
        clear_merge();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: two sources, saturating combine, extremes, ignored items
        write_sources(5'd2);
        send(make_rec(0, 0, 56'h0, 64'h0, 32'h0, 40'h0, 32'hFFFF_FFF0));
        send(make_rec(0, 0, 56'h1, 64'h1, 32'h1, 40'h1, 32'h1));     // head already held
        send(make_rec(5, 0, '1, '1, '1, '1, '1));                    // beyond live count
        send(make_rec(1, 0, 56'h0, 64'h0, 32'h0, 40'h0, 32'h20));    // equal key, tie on index
        send(make_rec(0, 0, 56'h0, 64'h0, 32'h0, 40'h0, 32'h7));     // equal key, combined without saturating
        send(make_rec(1, 0, '1, '1, '1, '1, '1));
        send(make_rec(0, 0, '1, '1, '1, '1, 32'h0));
        send(make_rec(0, 1, '1, '1, '1, '1, '1));
        send(make_rec(1, 1, 56'h0, 64'h0, 32'h0, 40'h0, 32'h0));
        send(make_rec(1, 0, 56'h5, 64'h5, 32'h5, 40'h5, 32'h5));     // source already ended
        wait_idle();
        // a count of zero acts as one; source 0 ends and flushes the held record
        write_sources(5'd0);
        send(make_rec(0, 1, 56'h0, 64'h0, 32'h0, 40'h0, 32'h0));
        send(make_rec(0, 0, 56'h12, 64'hAB, 32'h3, 40'h4, 32'h9));
        send(make_rec(0, 1, '1, '1, '1, '1, '1));
        wait_idle();
        // all sixteen sources, a single record each, then every stream ends
        write_sources(5'd16);
        for (int i = 0; i < MAX_SOURCES; i++)
            send(make_rec(i, 0, 56'h40, 64'h1, 32'h2, 40'h3, 32'h1));
        for (int i = 0; i < MAX_SOURCES; i++)
            send(make_rec(i, 1, 56'h0, 64'h0, 32'h0, 40'h0, 32'h0));
        wait_idle();

        // random merges across several source counts
        phase = 0;
        while (useful_items < ITEM_TARGET) begin
            write_sources((phase < 6) ? phase_cfg[phase] : 5'($urandom_range(0, 31)));
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 3 && useful_items < ITEM_TARGET; k++) random_merge();
            wait_idle();
            phase++;
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
